[hw/rtl/mvb_pkg.sv]
package mvb_pkg;

	localparam int unsigned COORD_W  = 32;
	localparam int unsigned WEIGHT_W = 18;
	localparam int unsigned SPEED_W  = 17;
	localparam int unsigned CFG_W    = 18;
	localparam int unsigned NUM_COORD = 5;

	// weight of one whole pose, q2.16
	localparam logic signed [WEIGHT_W-1:0] W_ONE  = 18'sd65536;
	localparam logic signed [WEIGHT_W-1:0] W_ZERO = 18'sd0;

	typedef enum logic [1:0] {
		REG_BLEND_SPEED  = 2'd0,
		REG_PING_PONG    = 2'd1,
		REG_BLEND_ENABLE = 2'd2,
		REG_START_WEIGHT = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic             we;
		reg_idx_t         index;
		logic [CFG_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic load_s2;
		logic load_s3;
	} lane_ctrl_t;

endpackage

[hw/rtl/morph_vertex_blend_top.sv]
// channel  | group      | content
// ---------+------------+------------------------------------------------------
// input    | s_axis_*   | tuser: frame_start; tdata: a_x..a_v, b_x..b_v
// output   | m_axis_*   | tdata: out_x, out_y, out_z, out_u, out_v
// config   | cfg_*      | write enable, register index, 18-bit data
//
// one vertex per cycle sustained while m_axis_tready does not hold the output
// the stages are input register, product register (one 33x18 multiply per
// coordinate) and result register (add, round, clamp)
// any empty stage lets the input take a transfer while a result waits
// reset clears all valid bits, the config registers and the weight state
module morph_vertex_blend_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [319:0] s_axis_tdata,  // a_x, a_y, a_z, a_u, a_v, b_x, b_y, b_z, b_u, b_v
	input  logic         s_axis_tuser,  // frame_start
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [159:0] m_axis_tdata,  // out_x, out_y, out_z, out_u, out_v
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [17:0]  cfg_data
);

	mvb_pkg::cfg_wr_t    cfg;
	mvb_pkg::lane_ctrl_t lane_ctrl;

	logic               accept;
	logic               load_s1;
	logic               load_s2;
	logic               load_s3;
	logic               valid_s1;
	logic               valid_s2;
	logic               valid_s3;
	logic [319:0]       data_s1;
	logic signed [17:0] weight_s1;
	logic               bypass_s1;
	logic signed [17:0] weight_use;
	logic               bypass;

	assign cfg.we    = cfg_we;
	assign cfg.index = mvb_pkg::reg_idx_t'(cfg_index);
	assign cfg.data  = cfg_data;

	assign load_s3 = !valid_s3 || m_axis_tready;
	assign load_s2 = !valid_s2 || load_s3;
	assign load_s1 = !valid_s1 || load_s2;

	assign s_axis_tready = load_s1;
	assign accept        = s_axis_tvalid && load_s1;
	assign m_axis_tvalid = valid_s3;

	assign lane_ctrl.load_s2 = load_s2;
	assign lane_ctrl.load_s3 = load_s3;

	mvb_weight u_weight (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.advance    (accept && s_axis_tuser),
		.weight_use (weight_use),
		.bypass     (bypass)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
			if (load_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1   <= s_axis_tdata;
			weight_s1 <= weight_use;
			bypass_s1 <= bypass;
		end
	end

	for (genvar k = 0; k < mvb_pkg::NUM_COORD; k++) begin : g_lane
		mvb_lane u_lane (
			.clk    (clk),
			.ctrl   (lane_ctrl),
			.a      ($signed(data_s1[32*k +: 32])),
			.b      ($signed(data_s1[160 + 32*k +: 32])),
			.weight (weight_s1),
			.bypass (bypass_s1),
			.result (m_axis_tdata[32*k +: 32])
		);
	end

`ifndef ASSERT_OFF
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with the result register empty");
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> valid_s1)
		else $error("input transfer lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && valid_s3 && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while every stage is full");
`endif

endmodule

[hw/rtl/mvb_weight.sv]
module mvb_weight (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mvb_pkg::cfg_wr_t     cfg,
	input  logic                 advance,
	output logic signed [17:0]   weight_use,
	output logic                 bypass
);

	logic [16:0]          speed_q;
	logic                 ping_pong_q;
	logic                 enable_q;
	logic signed [17:0]   weight_q;
	logic                 going_down_q;

	logic                 step;
	logic signed [17:0]   w_base;
	logic                 dir_down;
	logic signed [19:0]   w_ext;
	logic signed [19:0]   s_ext;
	logic signed [19:0]   w_sum;
	logic signed [17:0]   w_next;

	assign step = advance && enable_q;

	always_comb begin
		w_base   = weight_q;
		dir_down = going_down_q;
		if (ping_pong_q) begin
			if (weight_q >= mvb_pkg::W_ONE) begin
				dir_down = 1'b1;
			end else if (weight_q <= mvb_pkg::W_ZERO) begin
				dir_down = 1'b0;
			end
		end else if (weight_q >= mvb_pkg::W_ONE) begin
			w_base = mvb_pkg::W_ZERO;
		end
		w_ext = {{2{w_base[17]}}, w_base};
		s_ext = $signed({3'b000, speed_q});
		w_sum = dir_down ? (w_ext - s_ext) : (w_ext + s_ext);
		// clamp to the q2.16 range
		if ((w_sum[19:17] == 3'b000) || (w_sum[19:17] == 3'b111)) begin
			w_next = w_sum[17:0];
		end else if (w_sum[19]) begin
			w_next = {1'b1, 17'd0};
		end else begin
			w_next = {1'b0, {17{1'b1}}};
		end
	end

	assign weight_use = step ? w_next : weight_q;
	assign bypass     = !enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q      <= '0;
			ping_pong_q  <= 1'b0;
			enable_q     <= 1'b0;
			weight_q     <= '0;
			going_down_q <= 1'b0;
		end else if (cfg.we) begin
			unique case (cfg.index)
				mvb_pkg::REG_BLEND_SPEED:  speed_q     <= cfg.data[16:0];
				mvb_pkg::REG_PING_PONG:    ping_pong_q <= cfg.data[0];
				mvb_pkg::REG_BLEND_ENABLE: enable_q    <= cfg.data[0];
				mvb_pkg::REG_START_WEIGHT: weight_q    <= $signed(cfg.data);
				default: ;
			endcase
		end else if (step) begin
			weight_q     <= w_next;
			going_down_q <= dir_down;
		end
	end

`ifndef ASSERT_OFF
	assert property (@(posedge clk) disable iff (!arst_n)
		!step && !cfg.we |=> $stable(weight_q))
		else $error("weight moved without a frame start");
	assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(going_down_q))
		else $error("direction moved without a frame start");
	assert property (@(posedge clk) disable iff (!arst_n)
		step && !cfg.we && ping_pong_q && (weight_q >= mvb_pkg::W_ONE) |=> going_down_q)
		else $error("ping-pong did not turn at the top");
`endif

endmodule

[hw/rtl/mvb_lane.sv]
module mvb_lane (
	input  logic                  clk,
	input  mvb_pkg::lane_ctrl_t   ctrl,
	input  logic signed [31:0]    a,
	input  logic signed [31:0]    b,
	input  logic signed [17:0]    weight,
	input  logic                  bypass,
	output logic [31:0]           result
);

	logic signed [32:0] diff;
	logic signed [50:0] prod_s2;
	logic signed [31:0] b_s2;
	logic               bypass_s2;
	logic signed [51:0] t_sum;
	logic signed [35:0] q_val;
	logic [31:0]        sat;
	logic [31:0]        res_s3;

	// a*w + b*(1-w) == (a-b)*w + b*1
	assign diff = {a[31], a} - {b[31], b};

	always_ff @(posedge clk) begin
		if (ctrl.load_s2) begin
			prod_s2   <= diff * weight;
			b_s2      <= b;
			bypass_s2 <= bypass;
		end
	end

	// b shifted up by 16 with the rounding half in the low bits
	assign t_sum = {prod_s2[50], prod_s2}
		+ $signed({{4{b_s2[31]}}, b_s2, 16'h8000});
	assign q_val = t_sum[51:16];

	always_comb begin
		if ((q_val[35:31] == 5'b00000) || (q_val[35:31] == 5'b11111)) begin
			sat = q_val[31:0];
		end else if (q_val[35]) begin
			sat = {1'b1, 31'd0};
		end else begin
			sat = {1'b0, {31{1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_s3) begin
			res_s3 <= bypass_s2 ? b_s2 : sat;
		end
	end

	assign result = res_s3;

endmodule

[bench/tb_morph_vertex_blend_top.sv]
`timescale 1ns / 100ps

module tb_morph_vertex_blend_top;
	import mvb_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 12;
	localparam int IDLE_PCT       = 28;
	localparam int NUM_PHASES     = 10;
	localparam int PHASE_ITEMS    = 75;
	localparam int MAX_REPORTS    = 10;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [NUM_COORD-1:0][COORD_W-1:0] pos_t;

	typedef struct packed {
		logic frame_start;
		pos_t a;
		pos_t b;
	} vertex_t;

	localparam coord_t COORD_HI = 32'sh7fffffff;
	localparam coord_t COORD_LO = 32'sh80000000;
	localparam longint SAT_HI   = 64'sd2147483647;
	localparam longint SAT_LO   = -64'sd2147483648;
	localparam longint WGT_HI   = 64'sd131071;
	localparam longint WGT_LO   = -64'sd131072;
	localparam longint HALF_LSB = 64'sd32768;

	localparam logic [CFG_W-1:0] START_MAX = 18'h1ffff;
	localparam logic [CFG_W-1:0] START_MIN = 18'h20000;
	localparam logic [CFG_W-1:0] SPEED_ALL = 18'h3ffff;

	localparam string FIELD_NAME [NUM_COORD] = '{"out_x", "out_y", "out_z", "out_u", "out_v"};

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [319:0] s_axis_tdata;
	logic         s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [159:0] m_axis_tdata;
	logic         cfg_we;
	logic [1:0]   cfg_index;
	logic [17:0]  cfg_data;

	// predictor copy of the registers and the weight state
	logic [SPEED_W-1:0]         speed_q;
	logic                       ping_pong_q;
	logic                       enable_q;
	logic signed [WEIGHT_W-1:0] weight_q;
	logic                       going_down_q;

	vertex_t vertex_backlog [$];
	pos_t    blended_due [$];
	vertex_t bus_vertex;
	logic    in_busy;
	logic    steady;
	int      mismatches;
	int      quiet_cycles;

	morph_vertex_blend_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void advance_weight();
		longint w;
		w = longint'(weight_q);
		if (ping_pong_q) begin
			if (w >= longint'(W_ONE))
				going_down_q = 1'b1;
			else if (w <= 0)
				going_down_q = 1'b0;
		end else if (w >= longint'(W_ONE)) begin
			w = 0;
		end
		if (going_down_q)
			w = w - longint'(speed_q);
		else
			w = w + longint'(speed_q);
		if (w > WGT_HI)
			w = WGT_HI;
		if (w < WGT_LO)
			w = WGT_LO;
		weight_q = w[WEIGHT_W-1:0];
	endfunction

	function automatic coord_t blend_coord(coord_t a, coord_t b,
			logic signed [WEIGHT_W-1:0] w);
		longint t;
		longint q;
		t = longint'(a) * longint'(w) + longint'(b) * (longint'(W_ONE) - longint'(w)) + HALF_LSB;
		// floor shift, same as rounding half toward plus infinity
		q = t >>> 16;
		if (q > SAT_HI)
			q = SAT_HI;
		if (q < SAT_LO)
			q = SAT_LO;
		return q[COORD_W-1:0];
	endfunction

	function automatic pos_t blend_vertex(vertex_t v);
		pos_t r;
		int   i;
		if (!enable_q)
			return v.b;
		if (v.frame_start)
			advance_weight();
		for (i = 0; i < NUM_COORD; i++)
			r[i] = blend_coord(v.a[i], v.b[i], weight_q);
		return r;
	endfunction

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 7))
			0: return COORD_HI;
			1: return COORD_LO;
			2: return coord_t'(int'($urandom_range(0, 2 ** 20)) - 2 ** 19);
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic pos_t rand_pos();
		pos_t p;
		int   i;
		for (i = 0; i < NUM_COORD; i++)
			p[i] = rand_coord();
		return p;
	endfunction

	function automatic void queue_vertex(logic fs, pos_t a, pos_t b);
		vertex_t v;
		v.frame_start = fs;
		v.a = a;
		v.b = b;
		vertex_backlog.insert(vertex_backlog.size(), v);
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			REG_BLEND_SPEED:  speed_q = value[SPEED_W-1:0];
			REG_PING_PONG:    ping_pong_q = value[0];
			REG_BLEND_ENABLE: enable_q = value[0];
			REG_START_WEIGHT: weight_q = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (vertex_backlog.size() != 0 || in_busy || blended_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// both sides change at the falling edge
	always @(negedge clk) begin
		m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
		if (arst_n && !in_busy) begin
			if (vertex_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
				bus_vertex = vertex_backlog.pop_front();
				in_busy = 1'b1;
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {bus_vertex.b, bus_vertex.a};
				s_axis_tuser  <= bus_vertex.frame_start;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		pos_t want;
		pos_t got;
		int   i;
		// results first so a stray one cannot match an item taken this cycle
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (blended_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result transfer: %h", got);
			end else begin
				want = blended_due.pop_front();
				for (i = 0; i < NUM_COORD; i++) begin
					if (got[i] !== want[i]) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("%s mismatch: expected %h actual %h",
								FIELD_NAME[i], want[i], got[i]);
					end
				end
			end
		end
		if (s_axis_tvalid && s_axis_tready) begin
			blended_due.insert(blended_due.size(), blend_vertex(bus_vertex));
			in_busy = 1'b0;
		end
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int   phase;
		int   n;
		int   fs_every;
		pos_t hi_lo;
		pos_t lo_hi;

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		m_axis_tready = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_BLEND_SPEED;
		cfg_data      = '0;
		steady        = 1'b0;
		in_busy       = 1'b0;
		mismatches    = 0;
		quiet_cycles  = 0;
		speed_q       = '0;
		ping_pong_q   = 1'b0;
		enable_q      = 1'b0;
		weight_q      = '0;
		going_down_q  = 1'b0;
		hi_lo = {$urandom, $urandom, $urandom, COORD_LO, COORD_HI};
		lo_hi = {$urandom, $urandom, $urandom, COORD_HI, COORD_LO};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// blending off after reset: pose b passes, frame start ignored
		queue_vertex(1'b1, {NUM_COORD{COORD_HI}}, {NUM_COORD{COORD_LO}});
		queue_vertex(1'b0, rand_pos(), rand_pos());
		wait_drained();

		// ping-pong at half steps, turning at both ends, with rounding halves on z and u
		write_reg(REG_BLEND_ENABLE, 18'd1);
		write_reg(REG_PING_PONG, 18'd1);
		write_reg(REG_BLEND_SPEED, 18'd32768);
		write_reg(REG_START_WEIGHT, 18'd0);
		repeat (6)
			queue_vertex(1'b1, {$urandom, coord_t'(-1), coord_t'(1), COORD_LO, COORD_HI},
				{$urandom, 32'd0, 32'd0, COORD_HI, COORD_LO});
		wait_drained();

		// wrap mode from the lowest weight, full step
		write_reg(REG_PING_PONG, 18'd0);
		write_reg(REG_BLEND_SPEED, 18'd65536);
		write_reg(REG_START_WEIGHT, START_MIN);
		repeat (4)
			queue_vertex(1'b1, hi_lo, lo_hi);
		wait_drained();

		// oversized step: weight saturates high, then results saturate both ways
		write_reg(REG_BLEND_SPEED, SPEED_ALL);
		write_reg(REG_START_WEIGHT, 18'd65535);
		queue_vertex(1'b1, hi_lo, lo_hi);
		queue_vertex(1'b0, lo_hi, hi_lo);
		wait_drained();

		// turn down at the top, then wrap mode keeps going down into saturation
		write_reg(REG_PING_PONG, 18'd1);
		write_reg(REG_START_WEIGHT, START_MAX);
		queue_vertex(1'b1, rand_pos(), rand_pos());
		wait_drained();
		write_reg(REG_PING_PONG, 18'd0);
		write_reg(REG_START_WEIGHT, START_MIN);
		queue_vertex(1'b1, hi_lo, lo_hi);
		wait_drained();
		write_reg(REG_PING_PONG, 18'd1);
		queue_vertex(1'b1, rand_pos(), rand_pos());
		wait_drained();

		// disabled: weight holds across a frame start
		write_reg(REG_BLEND_ENABLE, 18'd0);
		queue_vertex(1'b1, rand_pos(), rand_pos());
		wait_drained();
		write_reg(REG_BLEND_ENABLE, 18'd1);
		queue_vertex(1'b0, rand_pos(), rand_pos());
		wait_drained();

		for (phase = 0; phase < NUM_PHASES; phase++) begin
			steady = (phase == 4);
			if (phase == 0 || $urandom_range(0, 9) < 7) begin
				case ($urandom_range(0, 5))
					0: write_reg(REG_BLEND_SPEED, 18'd0);
					1: write_reg(REG_BLEND_SPEED, 18'd65536);
					2: write_reg(REG_BLEND_SPEED, SPEED_ALL);
					3: write_reg(REG_BLEND_SPEED, 18'($urandom_range(0, 4096)));
					default: write_reg(REG_BLEND_SPEED, 18'($urandom));
				endcase
			end
			if (phase == 0 || $urandom_range(0, 9) < 7)
				write_reg(REG_PING_PONG, 18'($urandom));
			if (phase == 0 || $urandom_range(0, 9) < 7)
				write_reg(REG_BLEND_ENABLE, {17'($urandom), 1'($urandom_range(0, 9) != 0)});
			if (phase == 0 || $urandom_range(0, 9) < 7) begin
				case ($urandom_range(0, 5))
					0: write_reg(REG_START_WEIGHT, START_MAX);
					1: write_reg(REG_START_WEIGHT, START_MIN);
					2: write_reg(REG_START_WEIGHT, 18'd0);
					3: write_reg(REG_START_WEIGHT, 18'd65536);
					default: write_reg(REG_START_WEIGHT, 18'($urandom));
				endcase
			end
			fs_every = $urandom_range(1, 12);
			for (n = 0; n < PHASE_ITEMS; n++)
				queue_vertex($urandom_range(1, fs_every) == 1, rand_pos(), rand_pos());
			wait_drained();
		end
		steady = 1'b0;

		if (mismatches == 0 && blended_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
